/* design/rc4_pkg.sv */
package rc4_pkg;

  localparam int BYTE_W     = 8;
  localparam int PERM_DEPTH = 256;

  localparam logic MODE_KEY  = 1'b0;
  localparam logic MODE_DATA = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SETUP,
    S_KS_A,
    S_KS_B,
    S_KS_C,
    S_KS_D,
    S_D_A,
    S_D_B,
    S_D_C,
    S_D_D,
    S_D_E
  } state_t;

endpackage

/* design/rc4_ram.sv */
module rc4_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/rc4_stream_cipher.sv */
// RC4 engine. Key bytes (mode 0) are taken one per cycle into the key store while the
// engine is idle; the key byte flagged last starts the schedule (an identity fill of the
// permutation memory in state SETUP, then 256 steps through states KS_A to KS_D), which
// leaves i, j and the key count cleared. A data byte (mode 1) runs states D_A to
// D_E, and D_E holds until the output register is free, then loads the result; the next
// request is taken once the result is loaded. The permutation memory has one read and one
// write port with a registered read, so each swap costs two dependent reads and two writes.
// After reset the permutation memory is filled with identity, during which no request is
// taken. Key bytes beyond KEY_MAX are dropped; their last flag still starts the schedule.
module rc4_stream_cipher #(
  parameter int KEY_MAX = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       mode,
  input  logic [7:0] in_byte,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_out
);

  localparam int CW   = $clog2(KEY_MAX + 1);
  localparam int KA_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int BW   = rc4_pkg::BYTE_W;
  localparam int PA_W = $clog2(rc4_pkg::PERM_DEPTH);
  localparam logic [PA_W-1:0] LAST_N = PA_W'(rc4_pkg::PERM_DEPTH - 1);

  rc4_pkg::state_t state, state_next;

  logic [PA_W-1:0] n;
  logic [PA_W-1:0] i;
  logic [PA_W-1:0] j;
  logic [KA_W-1:0] k;
  logic [CW-1:0]   key_count;
  logic [BW-1:0]   a_reg;
  logic [BW-1:0]   b_reg;
  logic [BW-1:0]   byte_reg;
  logic            last_reg;
  logic            fwd;

  logic            perm_we;
  logic [PA_W-1:0] perm_wa;
  logic [BW-1:0]   perm_wd;
  logic [PA_W-1:0] perm_ra;
  logic [BW-1:0]   perm_rdata;
  logic            key_we;
  logic [BW-1:0]   key_rdata;

  logic            in_accept;
  logic            can_store;
  logic            out_free;
  logic [BW-1:0]   kb;
  logic [PA_W-1:0] jn_ks;
  logic [PA_W-1:0] jn_data;
  logic [PA_W-1:0] t_addr;
  logic [BW-1:0]   ks;
  logic [CW-1:0]   k_inc;
  logic [KA_W-1:0] k_next;

  assign in_ready  = (state == rc4_pkg::S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign can_store = (key_count < CW'(KEY_MAX));
  assign key_we    = in_accept && (mode == rc4_pkg::MODE_KEY) && can_store;
  assign out_free  = !out_valid || out_ready;

  assign kb      = (key_count == '0) ? '0 : key_rdata;
  assign jn_ks   = j + perm_rdata + kb;
  assign jn_data = j + perm_rdata;
  assign t_addr  = a_reg + b_reg;
  assign ks      = fwd ? a_reg : perm_rdata;
  assign k_inc   = CW'(k) + CW'(1);
  assign k_next  = (k_inc >= key_count) ? '0 : k_inc[KA_W-1:0];

  rc4_ram #(
    .DEPTH(rc4_pkg::PERM_DEPTH),
    .AW   (PA_W),
    .DW   (BW)
  ) u_perm (
    .clk  (clk),
    .we   (perm_we),
    .waddr(perm_wa),
    .wdata(perm_wd),
    .raddr(perm_ra),
    .rdata(perm_rdata)
  );

  rc4_ram #(
    .DEPTH(KEY_MAX),
    .AW   (KA_W),
    .DW   (BW)
  ) u_key (
    .clk  (clk),
    .we   (key_we),
    .waddr(key_count[KA_W-1:0]),
    .wdata(in_byte),
    .raddr(k),
    .rdata(key_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      rc4_pkg::S_CLEAR: begin
        if (n == LAST_N) state_next = rc4_pkg::S_IDLE;
      end
      rc4_pkg::S_IDLE: begin
        if (in_accept) begin
          if (mode == rc4_pkg::MODE_DATA) begin
            state_next = rc4_pkg::S_D_A;
          end else if (last) begin
            state_next = rc4_pkg::S_SETUP;
          end
        end
      end
      rc4_pkg::S_SETUP: begin
        if (n == LAST_N) state_next = rc4_pkg::S_KS_A;
      end
      rc4_pkg::S_KS_A: state_next = rc4_pkg::S_KS_B;
      rc4_pkg::S_KS_B: state_next = rc4_pkg::S_KS_C;
      rc4_pkg::S_KS_C: state_next = rc4_pkg::S_KS_D;
      rc4_pkg::S_KS_D: begin
        state_next = (n == LAST_N) ? rc4_pkg::S_IDLE : rc4_pkg::S_KS_A;
      end
      rc4_pkg::S_D_A: state_next = rc4_pkg::S_D_B;
      rc4_pkg::S_D_B: state_next = rc4_pkg::S_D_C;
      rc4_pkg::S_D_C: state_next = rc4_pkg::S_D_D;
      rc4_pkg::S_D_D: state_next = rc4_pkg::S_D_E;
      rc4_pkg::S_D_E: begin
        if (out_free) state_next = rc4_pkg::S_IDLE;
      end
      default: state_next = rc4_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    perm_we = 1'b0;
    perm_wa = n;
    perm_wd = n;
    perm_ra = n;
    case (state)
      rc4_pkg::S_CLEAR, rc4_pkg::S_SETUP: begin
        perm_we = 1'b1;
      end
      rc4_pkg::S_KS_B: begin
        perm_ra = jn_ks;
      end
      rc4_pkg::S_KS_C: begin
        perm_we = 1'b1;
        perm_wd = perm_rdata;
      end
      rc4_pkg::S_KS_D: begin
        perm_we = 1'b1;
        perm_wa = j;
        perm_wd = a_reg;
      end
      rc4_pkg::S_D_A: begin
        perm_ra = i + PA_W'(1);
      end
      rc4_pkg::S_D_B: begin
        perm_ra = jn_data;
      end
      rc4_pkg::S_D_C: begin
        perm_we = 1'b1;
        perm_wa = i;
        perm_wd = perm_rdata;
      end
      rc4_pkg::S_D_D: begin
        perm_we = 1'b1;
        perm_wa = j;
        perm_wd = a_reg;
        perm_ra = t_addr;
      end
      rc4_pkg::S_D_E: begin
        perm_ra = t_addr;
      end
      default: begin
        perm_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rc4_pkg::S_CLEAR;
      n         <= '0;
      i         <= '0;
      j         <= '0;
      key_count <= '0;
      out_valid <= 1'b0;
      fwd       <= 1'b0;
    end else begin
      state <= state_next;
      // keystream entry is the one being written this cycle
      fwd   <= (state == rc4_pkg::S_D_D) && (t_addr == j);
      if ((state == rc4_pkg::S_D_E) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        rc4_pkg::S_CLEAR, rc4_pkg::S_SETUP: begin
          n <= n + PA_W'(1);
        end
        rc4_pkg::S_IDLE: begin
          if (in_accept) begin
            byte_reg <= in_byte;
            last_reg <= last;
            if (mode == rc4_pkg::MODE_KEY) begin
              if (can_store) key_count <= key_count + CW'(1);
              if (last) begin
                j <= '0;
                k <= '0;
              end
            end
          end
        end
        rc4_pkg::S_KS_B: begin
          a_reg <= perm_rdata;
          j     <= jn_ks;
        end
        rc4_pkg::S_KS_D: begin
          n <= n + PA_W'(1);
          k <= k_next;
          if (n == LAST_N) begin
            i         <= '0;
            j         <= '0;
            key_count <= '0;
          end
        end
        rc4_pkg::S_D_A: begin
          i <= i + PA_W'(1);
        end
        rc4_pkg::S_D_B: begin
          a_reg <= perm_rdata;
          j     <= jn_data;
        end
        rc4_pkg::S_D_C: begin
          b_reg <= perm_rdata;
        end
        rc4_pkg::S_D_E: begin
          if (out_free) begin
            out_byte <= byte_reg ^ ks;
            last_out <= last_reg;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
